@@ hw/rtl/prc_pkg.sv @@
`default_nettype none

package prc_pkg;

    localparam int unsigned AddrW  = 48;
    localparam int unsigned CheckW = 8;

    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic [7:0] CRC_INIT       = 8'h07;
    localparam logic [7:0] CRC_ZERO_SUBST = 8'h08;

    localparam logic OP_PAIR  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [7:0][AddrW-1:0] t_crc_mask;

    typedef struct packed {
        logic       added;
        logic       in_range;
        logic [1:0] id;
        logic [1:0] count;
    } t_tbl_res;

    // bitwise CRC-8, MSB first, bytes low to high; elaboration use only
    function automatic logic [7:0] crc_calc(input logic [AddrW-1:0] addr,
                                            input logic [7:0] init);
        logic [7:0] c;
        c = init;
        for (int b = 0; b < AddrW / 8; b++) begin
            c = c ^ addr[8*b +: 8];
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
        end
        return c;
    endfunction

    // mask j of the linear part: the address bits that feed CRC bit j
    function automatic t_crc_mask crc_masks();
        t_crc_mask  m;
        logic [7:0] c;
        m = '0;
        for (int i = 0; i < AddrW; i++) begin
            c = crc_calc(AddrW'(1) << i, 8'h00);
            for (int j = 0; j < 8; j++) begin
                m[j][i] = c[j];
            end
        end
        return m;
    endfunction

    localparam t_crc_mask  CrcMask    = crc_masks();
    localparam logic [7:0] CrcZeroAdr = crc_calc('0, CRC_INIT);

endpackage

`default_nettype wire

@@ hw/rtl/pairing_registry_with_crc8.sv @@
// Timing: start is captured into the request register, and the result and its strobe
//   are then captured into the result register.
// Throughput: one transaction per cycle; busy stays low, the request register
//   feeds CRC, table lookup and insert combinationally into the result register.
// The receiver cannot stall; every result is shown for one cycle.
// Reset (synchronous, active low) empties the table and clears the strobes.
`default_nettype none

module pairing_registry_with_crc8 #(
    parameter int unsigned TABLE_DEPTH = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_op,
    input  wire logic [prc_pkg::CheckW-1:0]        i_check_byte,
    input  wire logic [prc_pkg::AddrW-1:0]         i_device_address,
    output logic                                   o_strobe,
    output logic      [prc_pkg::CheckW-1:0]        o_reply_check,
    output logic      [1:0]                        o_tracker_id,
    output logic                                   o_added,
    output logic      [1:0]                        o_table_count
);

    logic                          r_vld;
    logic                          r_op;
    logic [prc_pkg::CheckW-1:0]    r_check;
    logic [prc_pkg::AddrW-1:0]     r_addr;
    logic [7:0]                    w_crc;
    logic                          w_crc_ok;
    prc_pkg::t_tbl_res             w_res;
    logic [prc_pkg::CheckW-1:0]    n_reply;

    logic                          r_strobe;
    logic [prc_pkg::CheckW-1:0]    r_reply;
    logic [1:0]                    r_id;
    logic                          r_added;
    logic [1:0]                    r_count;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_op;
            r_check <= i_check_byte;
            r_addr  <= i_device_address;
        end
    end

    prc_crc8 u_crc (
        .i_addr (r_addr),
        .o_crc  (w_crc)
    );

    assign w_crc_ok = (w_crc == r_check);

    prc_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld),
        .i_op     (r_op),
        .i_addr   (r_addr),
        .i_crc_ok (w_crc_ok),
        .o_res    (w_res)
    );

    assign n_reply = ((r_op == prc_pkg::OP_PAIR) && w_crc_ok && w_res.in_range)
                     ? r_check : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_reply <= n_reply;
            r_id    <= w_res.id;
            r_added <= w_res.added;
            r_count <= w_res.count;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_reply_check = r_reply;
    assign o_tracker_id  = r_id;
    assign o_added       = r_added;
    assign o_table_count = r_count;

endmodule

`default_nettype wire

@@ hw/rtl/prc_crc8.sv @@
`default_nettype none

module prc_crc8 (
    input  wire logic [prc_pkg::AddrW-1:0] i_addr,
    output logic      [7:0]                o_crc
);

    logic [7:0] w_crc;

    // CRC is affine in the address: constant part xor parity of masked bits
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_crc[j] = prc_pkg::CrcZeroAdr[j] ^ (^(i_addr & prc_pkg::CrcMask[j]));
        end
    end

    assign o_crc = (w_crc == 8'h00) ? prc_pkg::CRC_ZERO_SUBST : w_crc;

endmodule

`default_nettype wire

@@ hw/rtl/prc_table.sv @@
`default_nettype none

module prc_table #(
    parameter int unsigned TABLE_DEPTH = 3
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_op,
    input  wire logic [prc_pkg::AddrW-1:0]   i_addr,
    input  wire logic                        i_crc_ok,
    output prc_pkg::t_tbl_res                o_res
);

    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

    logic [prc_pkg::AddrW-1:0] r_table [TABLE_DEPTH];
    logic [CntW-1:0]           r_count;
    logic [CntW-1:0]           n_count;
    logic [CntW-1:0]           w_id;
    logic                      w_addr_nz;
    logic                      w_wr;
    logic [CntW+1:0]           w_id_ext;
    logic [CntW+1:0]           w_cnt_ext;

    assign w_addr_nz = (i_addr != '0);

    // highest matching slot wins
    always_comb begin
        w_id = r_count;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_addr_nz && (CntW'(i) < r_count) && (r_table[i] == i_addr)) begin
                w_id = CntW'(i);
            end
        end
    end

    assign w_wr = i_valid && (i_op == prc_pkg::OP_PAIR) && i_crc_ok && w_addr_nz
                  && (w_id == r_count) && (r_count < CntW'(TABLE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_valid) begin
            if (i_op == prc_pkg::OP_CLEAR) begin
                n_count = '0;
            end else if (w_wr) begin
                n_count = r_count + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_wr && (r_count == CntW'(i))) begin
                r_table[i] <= i_addr;
            end
        end
    end

    assign w_id_ext  = (i_op == prc_pkg::OP_CLEAR) ? '0 : {2'b00, w_id};
    assign w_cnt_ext = {2'b00, n_count};

    always_comb begin
        o_res.added    = w_wr;
        o_res.in_range = (w_id < CntW'(TABLE_DEPTH));
        o_res.id       = w_id_ext[1:0];
        o_res.count    = w_cnt_ext[1:0];
    end

endmodule

`default_nettype wire
